### hdl/min_tracking_stack_top_assert.svh
// assertion macros for the min tracking stack checker
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define MSK_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("min tracking stack: same-cycle check failed");

// condition holds in the cycle after the trigger
`define MSK_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("min tracking stack: next-cycle check failed");

`endif

### hdl/msk_pkg.sv
// ---------------------------------------------------------------------------
// msk_pkg
// Types, sizes and codes shared by the min tracking stack modules.
// ---------------------------------------------------------------------------
package msk_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int WORD_W     = DATA_WIDTH + 2;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] msk_data_t;
  typedef logic signed [WORD_W-1:0]     msk_word_t;
  typedef logic [CNT_W-1:0]             msk_cnt_t;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } msk_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } msk_status_t;

  localparam msk_data_t DATA_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam msk_data_t DATA_NONE = '1;
  localparam msk_cnt_t  CNT_FULL  = CNT_W'(DEPTH);

  typedef struct packed {
    logic [1:0] opcode;
    msk_data_t  push_value;
  } msk_in_t;

  typedef struct packed {
    msk_data_t   top_value;
    msk_data_t   min_value;
    logic        is_empty;
    msk_cnt_t    entry_count;
    msk_status_t status;
  } msk_out_t;

  // shift control handed to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } msk_shift_t;

endpackage

### hdl/min_tracking_stack_top.sv
// ---------------------------------------------------------------------------
// min_tracking_stack_top
// LIFO of signed words with constant-time minimum, built as a shift chain.
// ---------------------------------------------------------------------------
//  channel   ports                          transfer when
//  input     start, busy, in_item           start high and busy low
//  result    out_valid, out_item            out_valid high, each result for one cycle only
//
// One operation per cycle; busy stays low. The result shows in the cycle
// after the transfer, read from the head cell of the chain and the min register.
// Push and pop move every cell of the chain by one place together.
// Synchronous active-low reset empties the stack and sets the min to the
// largest signed value; cell contents are left as they are.
// The result side cannot stall: each result is shown for exactly one cycle.
module min_tracking_stack_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  msk_pkg::msk_in_t  in_item,
  output logic              out_valid,
  output msk_pkg::msk_out_t out_item
);
  import msk_pkg::*;

  msk_shift_t                  shift;
  msk_word_t                   new_word;
  logic [DEPTH-1:0][WORD_W-1:0] cell_word;

  // operations never hold the input, so busy is tied low
  assign busy = 1'b0;

  msk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (start),
    .in_item   (in_item),
    .top_word  (msk_word_t'(cell_word[0])),
    .shift     (shift),
    .new_word  (new_word),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // chain of entries, head cell holds the top of stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    msk_word_t up_word;
    msk_word_t down_word;
    msk_word_t word;

    if (i == 0) begin : g_head
      assign up_word = new_word;
    end else begin : g_body
      assign up_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign down_word = '0;
    end else begin : g_link
      assign down_word = cell_word[i+1];
    end

    msk_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .up_word   (up_word),
      .down_word (down_word),
      .word      (word)
    );

    assign cell_word[i] = word;
  end

endmodule

### hdl/msk_cell.sv
// ---------------------------------------------------------------------------
// msk_cell
// One stack entry: loads from the neighbor above on push, below on pop.
// ---------------------------------------------------------------------------
module msk_cell (
  input  logic               clk,
  input  msk_pkg::msk_shift_t shift,
  input  msk_pkg::msk_word_t  up_word,
  input  msk_pkg::msk_word_t  down_word,
  output msk_pkg::msk_word_t  word
);
  import msk_pkg::*;

  msk_word_t word_r;

  // entry shifts toward the bottom on push, toward the top on pop
  always_ff @(posedge clk) begin
    if (shift.push) begin
      word_r <= up_word;
    end else if (shift.pop) begin
      word_r <= down_word;
    end
  end

  assign word = word_r;

endmodule

### hdl/msk_ctrl.sv
// ---------------------------------------------------------------------------
// msk_ctrl
// Count, running minimum, word encoding and result formatting.
// ---------------------------------------------------------------------------
module msk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  msk_pkg::msk_in_t   in_item,
  input  msk_pkg::msk_word_t top_word,
  output msk_pkg::msk_shift_t shift,
  output msk_pkg::msk_word_t new_word,
  output logic               out_valid,
  output msk_pkg::msk_out_t  out_item
);
  import msk_pkg::*;

  msk_cnt_t    count_r, count_nxt;
  msk_data_t   min_r, min_nxt;
  msk_status_t status_r, status_nxt;
  logic        valid_r;

  msk_word_t   x_word;
  msk_word_t   min_word;
  msk_word_t   enc_word;
  msk_word_t   restore_word;

  // widened operands for the encode and restore arithmetic
  assign x_word       = WORD_W'(in_item.push_value);
  assign min_word     = WORD_W'(min_r);
  assign enc_word     = (x_word <<< 1) - min_word;
  assign restore_word = (min_word <<< 1) - top_word;

  // next state for the operation
  always_comb begin
    count_nxt  = count_r;
    min_nxt    = min_r;
    status_nxt = ST_OK;
    shift      = '0;
    new_word   = x_word;
    if (accept) begin
      unique case (in_item.opcode)
        OP_PUSH: begin
          if (count_r == CNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            shift.push = 1'b1;
            count_nxt  = count_r + 1'b1;
            if (count_r == '0) begin
              min_nxt = in_item.push_value;
            end else if (x_word <= min_word) begin
              new_word = enc_word;
              min_nxt  = in_item.push_value;
            end
          end
        end
        OP_POP: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            shift.pop = 1'b1;
            count_nxt = count_r - 1'b1;
            if (top_word < min_word) begin
              min_nxt = restore_word[DATA_WIDTH-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      min_r    <= DATA_MAX;
      status_r <= ST_OK;
      valid_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      min_r    <= min_nxt;
      valid_r  <= accept;
      if (accept) begin
        status_r <= status_nxt;
      end
    end
  end

  // result decoded from the updated state: top is the larger of word and min, all ones when empty
  always_comb begin
    out_item.entry_count = count_r;
    out_item.status      = status_r;
    if (count_r == '0) begin
      out_item.top_value = DATA_NONE;
      out_item.min_value = DATA_NONE;
      out_item.is_empty  = 1'b1;
    end else begin
      out_item.top_value = (top_word > min_word) ? top_word[DATA_WIDTH-1:0] : min_r;
      out_item.min_value = min_r;
      out_item.is_empty  = 1'b0;
    end
  end

  assign out_valid = valid_r;

endmodule

### hdl/msk_chk.sv
// ---------------------------------------------------------------------------
// msk_chk
// Port-level checks on the min tracking stack, bound to the top level.
// ---------------------------------------------------------------------------
`include "min_tracking_stack_top_assert.svh"

module msk_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input msk_pkg::msk_out_t out_item
);
  import msk_pkg::*;

  // every transfer yields exactly one result on the next cycle
  `MSK_ASSERT_NEXT(a_result_follows, start && !busy, out_valid)
  `MSK_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !out_valid)

  // an empty stack reports no elements and reads -1
  `MSK_ASSERT_NOW(a_empty_view, out_valid && out_item.is_empty, (out_item.entry_count == '0) && (out_item.top_value == DATA_NONE) && (out_item.min_value == DATA_NONE))

  // the minimum never exceeds the top element
  `MSK_ASSERT_NOW(a_min_below_top, out_valid && !out_item.is_empty, out_item.min_value <= out_item.top_value)

  // a refused push only happens with a full stack
  `MSK_ASSERT_NOW(a_full_refusal, out_valid && (out_item.status == ST_FULL), out_item.entry_count == CNT_FULL)

endmodule

bind min_tracking_stack_top msk_chk u_msk_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

### tb/min_tracking_stack_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// min_tracking_stack_checker
// Watches the operation and result channels of the min tracking stack. It
// keeps its own copy of the stack, the running minimum and the entry count.
// For every accepted operation it works out the expected top, minimum, empty
// flag, count and status. Each result is then compared field by field with
// the oldest expectation.
// ---------------------------------------------------------------------------
module min_tracking_stack_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  msk_pkg::msk_in_t  in_item,
  input  logic              out_valid,
  input  msk_pkg::msk_out_t out_item,
  output int                fail_count,
  output int                pending
);
  import msk_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  // predicted stack contents, plain or encoded words
  msk_word_t stack_words [DEPTH];
  int        stack_depth;
  msk_data_t running_min;

  // stack views still waiting for their result transfer
  msk_out_t  stack_views_q [$];
  msk_out_t  want;
  int        errors = 0;

  assign fail_count = errors;
  assign pending    = stack_views_q.size();

  // apply one operation to the predicted stack and return the view after it
  function automatic msk_out_t apply_stack_op(logic [1:0] op, msk_data_t value);
    msk_out_t         view;
    msk_status_t      status;
    longint           val_l;
    longint           min_l;
    longint           word_l;
    logic [IDX_W-1:0] top_idx;
    status = ST_OK;
    val_l  = longint'(value);
    min_l  = longint'(running_min);
    case (op)
      OP_PUSH: begin
        if (stack_depth >= DEPTH) begin
          status = ST_FULL;
        end else if (stack_depth == 0) begin
          // first element is stored plainly and becomes the minimum
          stack_words[0] = msk_word_t'(value);
          running_min    = value;
          stack_depth    = 1;
        end else begin
          if (val_l > min_l) begin
            stack_words[stack_depth[IDX_W-1:0]] = msk_word_t'(value);
          end else begin
            // new minimum: keep the old one recoverable in the stored word
            stack_words[stack_depth[IDX_W-1:0]] = msk_word_t'(2 * val_l - min_l);
            running_min                         = value;
          end
          stack_depth++;
        end
      end
      OP_POP: begin
        if (stack_depth == 0) begin
          status = ST_EMPTY;
        end else begin
          stack_depth--;
          word_l = longint'(stack_words[stack_depth[IDX_W-1:0]]);
          // a word below the minimum marks where the minimum changed
          if (word_l < min_l) running_min = msk_data_t'(2 * min_l - word_l);
        end
      end
      default: ;
    endcase

    if (stack_depth == 0) begin
      view.top_value = DATA_NONE;
      view.min_value = DATA_NONE;
      view.is_empty  = 1'b1;
    end else begin
      top_idx = IDX_W'(stack_depth - 1);
      word_l  = longint'(stack_words[top_idx]);
      min_l   = longint'(running_min);
      view.top_value = msk_data_t'((word_l > min_l) ? word_l : min_l);
      view.min_value = running_min;
      view.is_empty  = 1'b0;
    end
    view.entry_count = msk_cnt_t'(stack_depth);
    view.status      = status;
    return view;
  endfunction

  // report one field that differs
  task automatic check_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val, act_val);
      errors++;
    end
  endtask

  // predict on each operation transfer, compare on each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      stack_depth = 0;
      running_min = DATA_MAX;
      stack_views_q.delete();
    end else begin
      if (start && !busy) begin
        stack_views_q.push_back(apply_stack_op(in_item.opcode, in_item.push_value));
      end
      if (out_valid) begin
        if (stack_views_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, out_item);
          errors++;
        end else begin
          want = stack_views_q.pop_front();
          check_field("top_value",   want.top_value,   out_item.top_value);
          check_field("min_value",   want.min_value,   out_item.min_value);
          check_field("is_empty",    32'(want.is_empty),    32'(out_item.is_empty));
          check_field("entry_count", 32'(want.entry_count), 32'(out_item.entry_count));
          check_field("status",      32'(want.status),      32'(out_item.status));
        end
      end
    end
  end

endmodule

### tb/min_tracking_stack_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// min_tracking_stack_top_tb
// Drives push, pop and query operations into the min tracking stack in
// random bursts and gaps. A short directed run covers the value extremes,
// pushes equal to the minimum, the empty refusal and the unused opcode.
// Random phases fill the stack, push when full, wander and drain it.
// A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module min_tracking_stack_top_tb;
  import msk_pkg::*;

  // unused opcode, behaves as a query
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam msk_data_t  DATA_MIN    = ~DATA_MAX;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  logic      out_valid;
  msk_in_t   in_item;
  msk_out_t  out_item;
  int        fail_count;
  int        pending;

  // stimulus-side view of the stack size, used only to shape phases
  int        depth_seen;
  int        burst_left;
  int        settle;
  msk_data_t last_pushed;

  min_tracking_stack_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  min_tracking_stack_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // random operation with given push and pop percentages
  function automatic logic [1:0] pick_op(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return OP_PUSH;
    if (r < push_pct + pop_pct) return OP_POP;
    if (r < 97) return OP_QUERY;
    return OP_RESERVED;
  endfunction

  // random value: full range, extremes, a narrow band and a slow descent
  function automatic msk_data_t pick_value();
    msk_data_t v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0: v = DATA_MIN;
          1: v = DATA_MAX;
          2: v = '0;
          default: v = DATA_NONE;
        endcase
      end
      4, 5, 6, 7: v = msk_data_t'(int'($urandom_range(0, 64)) - 32);
      default: v = last_pushed - msk_data_t'($urandom_range(0, 3));
    endcase
    last_pushed = v;
    return v;
  endfunction

  // one operation transfer, then a random gap at the end of a burst
  task automatic send_op(logic [1:0] op, msk_data_t value);
    int gap;
    @(negedge clk);
    start              <= 1'b1;
    in_item.opcode     <= op;
    in_item.push_value <= value;
    do @(posedge clk); while (busy);

    if (op == OP_PUSH && depth_seen < DEPTH) depth_seen++;
    else if (op == OP_POP && depth_seen > 0) depth_seen--;

    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        start   <= 1'b0;
        in_item <= {2'($urandom), $urandom};
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
    end
  endtask

  // stimulus
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    depth_seen  = 0;
    burst_left  = 1;
    last_pushed = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty stack, encoding extremes, equal minimum, unused opcode
    send_op(OP_QUERY, $urandom);
    send_op(OP_POP, $urandom);
    send_op(OP_RESERVED, $urandom);
    send_op(OP_PUSH, 32'sd5);
    send_op(OP_PUSH, 32'sd9);
    send_op(OP_PUSH, 32'sd5);
    send_op(OP_PUSH, DATA_MIN);
    send_op(OP_PUSH, DATA_MAX);
    send_op(OP_PUSH, DATA_MIN);
    send_op(OP_QUERY, $urandom);
    send_op(OP_RESERVED, $urandom);
    repeat (6) send_op(OP_POP, $urandom);
    send_op(OP_POP, $urandom);
    send_op(OP_PUSH, DATA_MAX);
    send_op(OP_PUSH, DATA_MIN);
    send_op(OP_PUSH, DATA_NONE);
    repeat (3) send_op(OP_POP, $urandom);
    send_op(OP_PUSH, '0);
    send_op(OP_POP, $urandom);

    // climb to full, then push against the full stack
    while (depth_seen < DEPTH) send_op(pick_op(88, 10), pick_value());
    repeat (8) send_op(pick_op(75, 0), pick_value());

    // wander around the upper half
    repeat (400) send_op(pick_op(46, 42), pick_value());

    // drain to empty, then pop against the empty stack
    while (depth_seen > 0) send_op(pick_op(8, 88), pick_value());
    repeat (6) send_op(pick_op(0, 90), pick_value());

    @(negedge clk);
    start <= 1'b0;

    // let outstanding results arrive
    settle = 0;
    while (pending != 0 && settle < 1000) begin
      @(negedge clk);
      settle++;
    end
    repeat (10) @(negedge clk);

    if (pending != 0) begin
      $display("%0t: results missing, expected %0d more, got none", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
